// ----- src/mpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpc_pkg: shared constants, types and helpers for the pixel colouriser
// image geometry, fixed-point format and saturation used by every file
// ----------------------------------------------------------------------------
package mpc_pkg;

  // image geometry and iteration limit
  localparam int IMAGE_WIDTH    = 500;
  localparam int IMAGE_HEIGHT   = 400;
  localparam int MAX_ITERATIONS = 255;

  // field widths
  localparam int COL_W   = 9;
  localparam int ROW_W   = 9;
  localparam int ZOOM_W  = 8;
  localparam int COLOR_W = 24;
  localparam int COUNT_W = 8;

  // fixed-point format: signed q6.26 in 32 bits
  localparam int FRAC_BITS = 26;
  localparam int Q_W       = 32;
  localparam int PROD_W    = 2 * Q_W;
  // widened value for sums of shifted products (|value| below 2^38)
  localparam int WIDE_W    = 40;

  // coordinate mapping: offset * zoom, then << FRAC_BITS and / IMAGE_WIDTH
  localparam int OFS_W  = 13;                    // pixel minus half size, signed
  localparam int PIX_W  = OFS_W + ZOOM_W;        // signed product
  localparam int MAG_W  = PIX_W - 1;             // its magnitude
  localparam int REM_W  = $clog2(IMAGE_WIDTH);

  // division by the width through reciprocals: whole part of magnitude / width,
  // then the fraction bits from the remainder
  localparam int HI_W   = MAG_W - REM_W + 1;            // whole quotient bits
  localparam int QUO_W  = HI_W + FRAC_BITS;             // full quotient bits
  localparam int HI_SH  = MAG_W + REM_W;
  localparam int HIM_W  = MAG_W + 1;
  localparam int HIP_W  = MAG_W + HIM_W;
  localparam int LO_SH  = REM_W + FRAC_BITS + REM_W;
  localparam int LOM_W  = REM_W + FRAC_BITS + 1;
  localparam int LOP_W  = REM_W + LOM_W;

  localparam logic [HIM_W-1:0] HI_RECIP =
    HIM_W'(((64'd1 << HI_SH) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH));
  localparam logic [LOM_W-1:0] LO_RECIP =
    LOM_W'(((64'd1 << LO_SH) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH));

  localparam logic [OFS_W-1:0] HALF_WIDTH  = OFS_W'(IMAGE_WIDTH / 2);
  localparam logic [OFS_W-1:0] HALF_HEIGHT = OFS_W'(IMAGE_HEIGHT / 2);

  // escape threshold 4.0
  localparam logic signed [WIDE_W-1:0] ESCAPE_LIMIT = WIDE_W'(4) <<< FRAC_BITS;

  // colour weights per iteration
  localparam logic [7:0] RED_STEP   = 8'd150;
  localparam logic [7:0] GREEN_STEP = 8'd50;
  localparam logic [7:0] BLUE_STEP  = 8'd25;

  localparam logic signed [ZOOM_W-1:0] ZOOM_RESET = ZOOM_W'(3);

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // clamp a widened value to the q6.26 range
  function automatic q_t sat_q(input wide_t v);
    q_t res;
    if (v[WIDE_W-1:Q_W-1] == '0 || v[WIDE_W-1:Q_W-1] == '1) begin
      res = v[Q_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = Q_MIN;
    end else begin
      res = Q_MAX;
    end
    return res;
  endfunction

  // floor of a full product shifted down by the fraction bits, widened
  function automatic wide_t shift_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-FRAC_BITS-1:0] s;
    s = p[PROD_W-1:FRAC_BITS];
    return WIDE_W'(s);
  endfunction

endpackage

// ----- src/mpc_if.sv -----
// ----------------------------------------------------------------------------
// mpc_if: ready/valid channels of the pixel colouriser
// pixel coordinate words in, colour words out
// ----------------------------------------------------------------------------
interface mpc_in_if;
  logic                      valid;
  logic                      ready;
  logic [mpc_pkg::COL_W-1:0] pixel_col;
  logic [mpc_pkg::ROW_W-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [mpc_pkg::COLOR_W-1:0] pixel_color;
  logic [mpc_pkg::COUNT_W-1:0] escape_count;

  modport source (output valid, output pixel_color, output escape_count, input ready);
  modport sink   (input valid, input pixel_color, input escape_count, output ready);
endinterface

// ----- src/mpc_div.sv -----
// ----------------------------------------------------------------------------
// mpc_div: coordinate divider
// (magnitude << frac) / image width by reciprocal products for the whole part,
// the remainder and its fraction, signed and clamped
// ----------------------------------------------------------------------------
module mpc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      neg,
  input  logic [mpc_pkg::MAG_W-1:0] mag,
  output logic                      busy,
  output mpc_pkg::q_t               coord
);
  import mpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HI,
    ST_REM,
    ST_LO
  } step_t;

  step_t             step_r;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic [HI_W-1:0]   hi_r;
  logic [REM_W-1:0]  rem_r;
  logic [FRAC_BITS-1:0] lo_r;

  logic [HIP_W-1:0]  hi_prod;
  logic [HI_W-1:0]   hi_nxt;
  logic [MAG_W-1:0]  whole;
  logic [REM_W-1:0]  rem_nxt;
  logic [LOP_W-1:0]  lo_prod;
  logic [FRAC_BITS-1:0] lo_nxt;
  logic [QUO_W-1:0]  quo;

  // whole part, remainder below the width, then the fraction of the remainder
  always_comb begin
    hi_prod = HIP_W'(mag_r) * HIP_W'(HI_RECIP);
    hi_nxt  = hi_prod[HI_SH +: HI_W];
    whole   = MAG_W'(hi_r) * MAG_W'(IMAGE_WIDTH);
    rem_nxt = REM_W'(mag_r - whole);
    lo_prod = LOP_W'(rem_r) * LOP_W'(LO_RECIP);
    lo_nxt  = lo_prod[(LO_SH - FRAC_BITS) +: FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      case (step_r)
        ST_IDLE: begin
          if (start) begin
            mag_r  <= mag;
            neg_r  <= neg;
            step_r <= ST_HI;
          end
        end
        ST_HI: begin
          hi_r   <= hi_nxt;
          step_r <= ST_REM;
        end
        ST_REM: begin
          rem_r  <= rem_nxt;
          step_r <= ST_LO;
        end
        ST_LO: begin
          lo_r   <= lo_nxt;
          step_r <= ST_IDLE;
        end
        default: begin
          step_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign quo = {hi_r, lo_r};

  // quotient truncated towards zero, sign applied, clamped to q6.26
  always_comb begin
    if (neg_r) begin
      if (quo > {{(QUO_W-Q_W){1'b0}}, 1'b1, {(Q_W-1){1'b0}}}) begin
        coord = Q_MIN;
      end else begin
        coord = -q_t'(quo[Q_W-1:0]);
      end
    end else begin
      if (quo[QUO_W-1:Q_W-1] != '0) begin
        coord = Q_MAX;
      end else begin
        coord = q_t'(quo[Q_W-1:0]);
      end
    end
  end

  assign busy = (step_r != ST_IDLE);

endmodule

// ----- src/mandelbrot_pixel_colorizer.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_pixel_colorizer: escape-time colouriser for one pixel a word
// maps a pixel to a point c, iterates z = z*z + c, colours by iteration count
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in_pix   in   valid/ready            pixel_col[8:0], pixel_row[8:0]
//  out_pix  out  valid/ready            pixel_color[23:0], escape_count[7:0]
//  cfg      in   cfg_wr_en, no ready    cfg_wr_data[7:0] = zoom_scale
//
//  the mapping uses two reciprocal dividers: whole part, remainder, fraction
//  each iteration runs x*x, y*y, then x*y on the single shared 32x32 multiplier
//  in_pix.ready is high only while idle; a held result does not block it
//  a finished word waits in its own state while out_pix still holds one
//  reset (rst_n low, synchronous) empties the output and sets zoom to 3
// ----------------------------------------------------------------------------
module mandelbrot_pixel_colorizer (
  input  logic                              clk,
  input  logic                              rst_n,
  mpc_in_if.sink                            in_pix,
  mpc_out_if.source                         out_pix,
  input  logic                              cfg_wr_en,
  input  logic signed [mpc_pkg::ZOOM_W-1:0] cfg_wr_data
);
  import mpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_SQX,
    S_SQY,
    S_CROSS,
    S_DONE
  } state_t;

  state_t                      state_r;
  logic signed [ZOOM_W-1:0]    zoom_r;

  // iteration registers
  q_t                          c_re_r, c_im_r;
  q_t                          x_r, y_r;
  wide_t                       xx_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic [COUNT_W-1:0]          n_r;
  logic                        pend_r;   // x*y of the last iteration waits in prod_r

  // output register
  logic                        out_valid_r;
  logic [COLOR_W-1:0]          color_r;
  logic [COUNT_W-1:0]          count_r;

  // coordinate mapping
  logic                        accept;
  logic signed [OFS_W-1:0]     ofs_re, ofs_im;
  logic signed [PIX_W-1:0]     pix_re, pix_im;
  logic [MAG_W-1:0]            mag_re, mag_im;
  logic                        re_busy, im_busy;
  q_t                          re_coord, im_coord;

  // shared multiplier and iteration datapath
  q_t                          mul_a, mul_b;
  logic signed [PROD_W-1:0]    mul_p;
  wide_t                       prod_s;
  wide_t                       mag_sq;
  logic                        escaped;
  q_t                          x_nxt, y_nxt;
  logic [COUNT_W-1:0]          n_nxt;
  logic [15:0]                 red_p, green_p, blue_p;
  logic [COLOR_W-1:0]          color_nxt;

  assign accept = in_pix.valid && in_pix.ready;
  assign in_pix.ready = (state_r == S_IDLE);

  // offsets from the image centre, scaled by zoom; magnitude goes to the dividers
  always_comb begin
    ofs_re = signed'(OFS_W'(in_pix.pixel_col)) - signed'(HALF_WIDTH);
    ofs_im = signed'(OFS_W'(in_pix.pixel_row)) - signed'(HALF_HEIGHT);
    pix_re = PIX_W'(ofs_re) * PIX_W'(zoom_r);
    pix_im = PIX_W'(ofs_im) * PIX_W'(zoom_r);
    mag_re = pix_re[PIX_W-1] ? MAG_W'(-pix_re) : pix_re[MAG_W-1:0];
    mag_im = pix_im[PIX_W-1] ? MAG_W'(-pix_im) : pix_im[MAG_W-1:0];
  end

  mpc_div u_div_re (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .neg   (pix_re[PIX_W-1]),
    .mag   (mag_re),
    .busy  (re_busy),
    .coord (re_coord)
  );

  mpc_div u_div_im (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .neg   (pix_im[PIX_W-1]),
    .mag   (mag_im),
    .busy  (im_busy),
    .coord (im_coord)
  );

  // operand select: x*x, then y*y, then x*y
  always_comb begin
    case (state_r)
      S_SQX: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      S_SQY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = y_r;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // prod_r holds y*y in the cross step and x*y in the square-x step
  always_comb begin
    prod_s    = shift_prod(prod_r);
    mag_sq    = xx_r + prod_s;
    escaped   = (mag_sq > ESCAPE_LIMIT);
    x_nxt     = sat_q(xx_r - prod_s + WIDE_W'(c_re_r));
    y_nxt     = sat_q((prod_s <<< 1) + WIDE_W'(c_im_r));
    n_nxt     = n_r + 1'b1;
    red_p     = n_r * RED_STEP;
    green_p   = n_r * GREEN_STEP;
    blue_p    = n_r * BLUE_STEP;
    // a point that stayed bounded is black
    if (n_r == COUNT_W'(MAX_ITERATIONS)) begin
      color_nxt = '0;
    end else begin
      color_nxt = {red_p[7:0], green_p[7:0], blue_p[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      zoom_r      <= ZOOM_RESET;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      n_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        zoom_r <= cfg_wr_data;
      end
      // the done state reloads the output register itself
      if (out_valid_r && out_pix.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MAP;
          end
        end

        S_MAP: begin
          if (!re_busy) begin
            c_re_r  <= re_coord;
            c_im_r  <= im_coord;
            x_r     <= '0;
            y_r     <= '0;
            n_r     <= '0;
            pend_r  <= 1'b0;
            state_r <= S_SQX;
          end
        end

        S_SQX: begin
          // finish the last iteration's y while x*x starts
          if (pend_r) begin
            y_r <= y_nxt;
          end
          prod_r  <= mul_p;
          state_r <= S_SQY;
        end

        S_SQY: begin
          xx_r    <= prod_s;
          prod_r  <= mul_p;
          state_r <= S_CROSS;
        end

        S_CROSS: begin
          if (escaped) begin
            state_r <= S_DONE;
          end else begin
            x_r     <= x_nxt;
            prod_r  <= mul_p;
            n_r     <= n_nxt;
            pend_r  <= 1'b1;
            if (n_nxt == COUNT_W'(MAX_ITERATIONS)) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_SQX;
            end
          end
        end

        S_DONE: begin
          if (!out_valid_r || out_pix.ready) begin
            out_valid_r <= 1'b1;
            color_r     <= color_nxt;
            count_r     <= n_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_pix.valid        = out_valid_r;
  assign out_pix.pixel_color  = color_r;
  assign out_pix.escape_count = count_r;

`ifndef SYNTH
  // both dividers start together and run the same number of steps
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    re_busy == im_busy)
    else $error("coordinate dividers out of step");

  // the count never passes the iteration limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r <= COUNT_W'(MAX_ITERATIONS)))
    else $error("escape count beyond limit");

  // a bounded point comes out black
  a_bounded_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && count_r == COUNT_W'(MAX_ITERATIONS)) |-> (color_r == '0))
    else $error("bounded pixel not black");

  // a pending cross product exists only once an iteration has completed
  a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQX && pend_r) |-> (n_r != '0))
    else $error("pending cross product without an iteration");

  // an accepted word moves the block into mapping with the re divider busy
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MAP && re_busy))
    else $error("mapping did not start after accept");
`endif

endmodule

// ----- sim/escape_time_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_time_checker: scoreboard for the pixel colouriser
// predicts the colour and iteration count of every accepted pixel word in
// q6.26 arithmetic and compares each result word against the oldest one
// ----------------------------------------------------------------------------
module escape_time_checker
  import mpc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  mpc_in_if                          pix_in,
  mpc_out_if                         pix_out,
  input  logic                       cfg_wr_en,
  input  logic signed [ZOOM_W-1:0]   cfg_wr_data,
  output int unsigned                fail_count,
  output int unsigned                words_pending
);

  localparam logic signed [ZOOM_W-1:0] ZOOM_AT_RESET = 8'sd3;
  localparam int RED_WEIGHT   = 150;
  localparam int GREEN_WEIGHT = 50;
  localparam int BLUE_WEIGHT  = 25;
  localparam longint BAILOUT  = longint'(4) <<< FRAC_BITS;

  typedef struct packed {
    logic [COLOR_W-1:0] colour;
    logic [COUNT_W-1:0] count;
  } shade_t;

  logic signed [ZOOM_W-1:0] zoom;
  shade_t                   awaited_shades[$];
  int unsigned              errors;

  function automatic q_t clamp_q(input longint v);
    q_t res;
    if (v > longint'(Q_MAX)) begin
      res = Q_MAX;
    end else if (v < longint'(Q_MIN)) begin
      res = Q_MIN;
    end else begin
      res = q_t'(v);
    end
    return res;
  endfunction

  // exact product, floored to the fraction grid
  function automatic longint fixed_mul(input q_t a, input q_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  // offset * zoom / image width, division truncating toward zero
  function automatic q_t offset_to_point(input int offset, input logic signed [ZOOM_W-1:0] z);
    longint num;
    num = longint'(offset) * longint'(z) * (longint'(1) <<< FRAC_BITS);
    return clamp_q(num / longint'(IMAGE_WIDTH));
  endfunction

  function automatic shade_t escape_colour(input logic [COL_W-1:0] col,
                                           input logic [ROW_W-1:0] row,
                                           input logic signed [ZOOM_W-1:0] z);
    q_t     c_re, c_im, x, y;
    longint xx, yy, xy;
    int     n;
    logic   escaped;
    shade_t s;
    c_re    = offset_to_point(int'(col) - IMAGE_WIDTH / 2, z);
    c_im    = offset_to_point(int'(row) - IMAGE_HEIGHT / 2, z);
    x       = '0;
    y       = '0;
    n       = 0;
    escaped = 1'b0;
    while (n < MAX_ITERATIONS && !escaped) begin
      xx = fixed_mul(x, x);
      yy = fixed_mul(y, y);
      if (xx + yy > BAILOUT) begin
        escaped = 1'b1;
      end else begin
        xy = fixed_mul(x, y);
        x  = clamp_q(xx - yy + longint'(c_re));
        y  = clamp_q(2 * xy + longint'(c_im));
        n++;
      end
    end
    s.count = COUNT_W'(n);
    if (n < MAX_ITERATIONS) begin
      s.colour = {8'(RED_WEIGHT * n), 8'(GREEN_WEIGHT * n), 8'(BLUE_WEIGHT * n)};
    end else begin
      s.colour = '0;
    end
    return s;
  endfunction

  always @(posedge clk) begin
    shade_t exp_s;
    if (!rst_n) begin
      zoom = ZOOM_AT_RESET;
      awaited_shades.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        zoom = cfg_wr_data;
      end
      if (pix_in.valid && pix_in.ready) begin
        awaited_shades.push_back(escape_colour(pix_in.pixel_col, pix_in.pixel_row, zoom));
      end
      if (pix_out.valid && pix_out.ready) begin
        if (awaited_shades.size() == 0) begin
          $display("%0t: unexpected result word colour %06h count %0d", $time,
                   pix_out.pixel_color, pix_out.escape_count);
          errors++;
        end else begin
          exp_s = awaited_shades.pop_front();
          if (pix_out.pixel_color !== exp_s.colour) begin
            $display("%0t: pixel_color expected %06h actual %06h", $time,
                     exp_s.colour, pix_out.pixel_color);
            errors++;
          end
          if (pix_out.escape_count !== exp_s.count) begin
            $display("%0t: escape_count expected %0d actual %0d", $time,
                     exp_s.count, pix_out.escape_count);
            errors++;
          end
        end
      end
    end
    fail_count    <= errors;
    words_pending <= awaited_shades.size();
  end

endmodule

// ----- sim/mandelbrot_pixel_colorizer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_pixel_colorizer_test: stimulus and verdict for the colouriser
// directed corner pixels over several zoom settings, then random pixels under
// three idling patterns; a checker beside the block scores every result word
// ----------------------------------------------------------------------------
module mandelbrot_pixel_colorizer_test;
  import mpc_pkg::*;

  localparam int RANDOM_PHASES   = 3;
  localparam int ZOOMS_PER_PHASE = 4;
  localparam int WORDS_PER_ZOOM  = 44;
  // longer than the longest word takes, so this covers any stray result
  localparam int SETTLE_CYCLES   = 1000;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic signed [ZOOM_W-1:0] cfg_wr_data;
  int unsigned              tx_idle_pct;
  int unsigned              rx_idle_pct;
  int unsigned              fail_count;
  int unsigned              words_pending;

  mpc_in_if  in_pix ();
  mpc_out_if out_pix ();

  mandelbrot_pixel_colorizer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (in_pix),
    .out_pix     (out_pix),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  escape_time_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix_in        (in_pix),
    .pix_out       (out_pix),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #50_000_000;
    $display("mandelbrot_pixel_colorizer_test failed");
    $finish;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_pix.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // offer one pixel word after random idle cycles, held until ready is seen high
  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid     <= 1'b1;
    in_pix.pixel_col <= col;
    in_pix.pixel_row <= row;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted word has come back
  // (the pending count is registered, hence the first step before looking)
  task automatic wait_drained();
    in_pix.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  // zoom changes only once the block has gone quiet
  task automatic set_zoom(input logic signed [ZOOM_W-1:0] z);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= z;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic signed [ZOOM_W-1:0] z;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;

    // everything known from time zero, reset held low before release
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_pix.valid     <= 1'b0;
    in_pix.pixel_col <= '0;
    in_pix.pixel_row <= '0;
    tx_idle_pct      <= 0;
    rx_idle_pct      <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset zoom of 3
    send_pixel(9'd0,   9'd0);     // top-left corner
    send_pixel(9'd499, 9'd399);   // bottom-right corner of the image
    send_pixel(9'd511, 9'd511);   // largest field values, beyond the image
    send_pixel(9'd500, 9'd400);   // first coordinates off the image
    send_pixel(9'd250, 9'd200);   // origin, never escapes
    send_pixel(9'd0,   9'd200);   // c = -1.5 on the real axis, bounded
    send_pixel(9'd499, 9'd200);   // far right, escapes after two iterations
    send_pixel(9'd250, 9'd0);     // top of the imaginary axis
    send_pixel(9'd125, 9'd200);   // c = -0.75, slow boundary point
    send_pixel(9'd256, 9'd255);   // single high bit against all low bits
    send_pixel(9'd170, 9'd341);   // alternating bit patterns
    send_pixel(9'd341, 9'd170);

    // largest positive zoom: mapped points saturate to the q6.26 range
    set_zoom(8'sd127);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd0,   9'd0);
    send_pixel(9'd250, 9'd330);
    send_pixel(9'd260, 9'd205);
    send_pixel(9'd250, 9'd200);

    // most negative zoom: image mirrored, saturation from the other side
    set_zoom(-8'sd128);
    send_pixel(9'd0,   9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd251, 9'd200);

    // zero zoom collapses every pixel onto the origin
    set_zoom(8'sd0);
    send_pixel(9'd37,  9'd311);
    send_pixel(9'd499, 9'd0);

    // random part: sender 30 / receiver 58, then swapped, then no idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      tx_idle_pct <= (ph == 0) ? 30 : (ph == 1) ? 58 : 0;
      rx_idle_pct <= (ph == 0) ? 58 : (ph == 1) ? 30 : 0;
      for (int zi = 0; zi < ZOOMS_PER_PHASE; zi++) begin
        // a fixed zoom first (64, -64 or 3 by phase), then mostly small zooms that show the set's detail
        if (zi == 0) begin
          z = (ph == 0) ? 8'sd64 : (ph == 1) ? -8'sd64 : 8'sd3;
        end else if ($urandom_range(3) != 0) begin
          z = ZOOM_W'($urandom_range(6, 1));
          if ($urandom_range(1) != 0) z = -z;
        end else begin
          z = ZOOM_W'($urandom_range(255));
        end
        set_zoom(z);
        for (int k = 0; k < WORDS_PER_ZOOM; k++) begin
          // now and then let the block run dry before the next word
          if ($urandom_range(49) == 0) wait_drained();
          if ($urandom_range(99) < 85) begin
            col = COL_W'($urandom_range(IMAGE_WIDTH - 1));
            row = ROW_W'($urandom_range(IMAGE_HEIGHT - 1));
          end else begin
            col = COL_W'($urandom_range(511));
            row = ROW_W'($urandom_range(511));
          end
          send_pixel(col, row);
        end
      end
    end

    // all words in: collect the rest, then watch for strays
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("mandelbrot_pixel_colorizer_test passed");
    end else begin
      $display("mandelbrot_pixel_colorizer_test failed");
    end
    $finish;
  end

endmodule
